[design/ffsa_pkg.sv]
// Package for the first-free slot allocator.
// Holds table geometry, field widths, status and mode codes, and sequencer states.
// No dependencies.
package ffsa_pkg;

    localparam int FLOORS          = 4;
    localparam int SLOTS_PER_FLOOR = 8;
    localparam int TOTAL_SLOTS     = FLOORS * SLOTS_PER_FLOOR;
    localparam int IDX_W           = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

    localparam int FLOOR_W = 2;
    localparam int SLOT_W  = 3;
    localparam int OWNER_W = 16;
    localparam int COUNT_W = 6;
    localparam int STAT_W  = 2;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_GRANTED  = 2'd0,
        ST_FULL     = 2'd1,
        ST_RELEASED = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_FINISH
    } state_t;

endpackage

[design/ffsa_req_if.sv]
// Request channel of the slot allocator: valid/ready plus the request payload.
// Depends on ffsa_pkg.
interface ffsa_req_if;
    import ffsa_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [OWNER_W-1:0] owner_id;
    logic [FLOOR_W-1:0] floor_in;
    logic [SLOT_W-1:0]  slot_in;

    modport source (output valid, output mode, output owner_id, output floor_in,
                    output slot_in, input ready);
    modport sink   (input valid, input mode, input owner_id, input floor_in,
                    input slot_in, output ready);
endinterface

[design/ffsa_rsp_if.sv]
// Response channel of the slot allocator: valid/ready plus the result payload.
// Depends on ffsa_pkg.
interface ffsa_rsp_if;
    import ffsa_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [FLOOR_W-1:0] floor_out;
    logic [SLOT_W-1:0]  slot_out;
    logic [COUNT_W-1:0] occupied_count;
    logic [OWNER_W-1:0] released_owner;

    modport source (output valid, output status, output floor_out, output slot_out,
                    output occupied_count, output released_owner, input ready);
    modport sink   (input valid, input status, input floor_out, input slot_out,
                    input occupied_count, input released_owner, output ready);
endinterface

[design/ffsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[design/first_free_slot_allocator.sv]
// Top level of the first-free slot allocator: sequencer, busy bits, count, result register.
// Depends on ffsa_pkg, ffsa_req_if, ffsa_rsp_if and ffsa_ram (owner store).
//
//  channel | dir | transaction
//  --------+-----+---------------------------------------------------------
//  req     | in  | mode, owner_id, floor_in, slot_in
//  rsp     | out | status, floor_out, slot_out, occupied_count, released_owner
//
// Allocate: S_IDLE accepts, S_SCAN tests one busy bit per cycle, S_FINISH loads the output
// register; a full table skips S_SCAN. Release: S_IDLE, S_READ (owner RAM read), S_FINISH;
// a rejected release skips S_READ. req.ready is high only while the sequencer idles;
// a finished result waits in the output register, and the sequencer holds its next result
// until rsp takes the previous one. Reset clears all busy bits and the count at once.
module first_free_slot_allocator (
    input  logic        clk,
    input  logic        rst_n,
    ffsa_req_if.sink    req,
    ffsa_rsp_if.source  rsp
);
    import ffsa_pkg::*;

    state_t               state_reg, state_next;
    logic [TOTAL_SLOTS-1:0] busy_reg, busy_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [FLOOR_W-1:0]   scan_floor_reg, scan_floor_next;
    logic [SLOT_W-1:0]    scan_slot_reg, scan_slot_next;
    logic [OWNER_W-1:0]   owner_reg, owner_next;

    status_t              res_status_reg, res_status_next;
    logic [FLOOR_W-1:0]   res_floor_reg, res_floor_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [OWNER_W-1:0]   res_owner_reg, res_owner_next;

    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [FLOOR_W-1:0]   out_floor_reg, out_floor_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;
    logic [OWNER_W-1:0]   out_owner_reg, out_owner_next;

    logic                 accept;
    logic                 out_free;
    logic                 table_full;
    logic                 rel_in_range;
    logic [IDX_W-1:0]     rel_idx;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_raddr;
    logic [OWNER_W-1:0]   ram_rdata;

    assign accept       = req.valid && req.ready;
    assign out_free     = !out_valid_reg || rsp.ready;
    assign table_full   = (count_reg >= COUNT_W'(TOTAL_SLOTS));
    assign rel_in_range = (int'(req.floor_in) < FLOORS) && (int'(req.slot_in) < SLOTS_PER_FLOOR);
    assign rel_idx      = IDX_W'(int'(req.floor_in) * SLOTS_PER_FLOOR + int'(req.slot_in));
    assign ram_raddr    = rel_idx;

    ffsa_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (TOTAL_SLOTS)
    ) u_owner_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (scan_idx_reg),
        .wdata (owner_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.mode == MODE_ALLOC)
                    begin
                        state_next = table_full ? S_FINISH : S_SCAN;
                    end
                    else
                    begin
                        state_next = (rel_in_range && busy_reg[rel_idx]) ? S_READ : S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                if (!busy_reg[scan_idx_reg] || scan_idx_reg == IDX_W'(TOTAL_SLOTS - 1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        busy_next       = busy_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        scan_floor_next = scan_floor_reg;
        scan_slot_next  = scan_slot_reg;
        owner_next      = owner_reg;
        res_status_next = res_status_reg;
        res_floor_next  = res_floor_reg;
        res_slot_next   = res_slot_reg;
        res_owner_next  = res_owner_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_floor_next  = out_floor_reg;
        out_slot_next   = out_slot_reg;
        out_count_next  = out_count_reg;
        out_owner_next  = out_owner_reg;
        ram_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    owner_next      = req.owner_id;
                    scan_idx_next   = '0;
                    scan_floor_next = '0;
                    scan_slot_next  = '0;
                    res_status_next = ST_REJECTED;
                    res_floor_next  = '0;
                    res_slot_next   = '0;
                    res_owner_next  = '0;
                    if (req.mode == MODE_ALLOC)
                    begin
                        if (table_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                    else if (rel_in_range && busy_reg[rel_idx])
                    begin
                        busy_next[rel_idx] = 1'b0;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - COUNT_W'(1);
                        end
                        res_status_next = ST_RELEASED;
                        res_floor_next  = req.floor_in;
                        res_slot_next   = req.slot_in;
                    end
                end
            end
            S_SCAN:
            begin
                if (!busy_reg[scan_idx_reg])
                begin
                    busy_next[scan_idx_reg] = 1'b1;
                    count_next      = count_reg + COUNT_W'(1);
                    ram_we          = 1'b1;
                    res_status_next = ST_GRANTED;
                    res_floor_next  = scan_floor_reg;
                    res_slot_next   = scan_slot_reg;
                end
                else if (scan_idx_reg == IDX_W'(TOTAL_SLOTS - 1))
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                    if (scan_slot_reg == SLOT_W'(SLOTS_PER_FLOOR - 1))
                    begin
                        scan_slot_next  = '0;
                        scan_floor_next = scan_floor_reg + FLOOR_W'(1);
                    end
                    else
                    begin
                        scan_slot_next = scan_slot_reg + SLOT_W'(1);
                    end
                end
            end
            S_READ:
            begin
                res_owner_next = ram_rdata;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_floor_next  = res_floor_reg;
                    out_slot_next   = res_slot_reg;
                    out_count_next  = count_reg;
                    out_owner_next  = res_owner_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        scan_floor_reg <= scan_floor_next;
        scan_slot_reg  <= scan_slot_next;
        owner_reg      <= owner_next;
        res_status_reg <= res_status_next;
        res_floor_reg  <= res_floor_next;
        res_slot_reg   <= res_slot_next;
        res_owner_reg  <= res_owner_next;
        out_status_reg <= out_status_next;
        out_floor_reg  <= out_floor_next;
        out_slot_reg   <= out_slot_next;
        out_count_reg  <= out_count_next;
        out_owner_reg  <= out_owner_next;
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.floor_out      = out_floor_reg;
    assign rsp.slot_out       = out_slot_reg;
    assign rsp.occupied_count = out_count_reg;
    assign rsp.released_owner = out_owner_reg;

`ifndef SYNTHESIS
    a_count_matches_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(busy_reg) == int'(count_reg))
        else $error("occupied count differs from busy bits");

    a_scan_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> !table_full)
        else $error("scan running on a full table");

    a_full_reports_all: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_FULL |-> rsp.occupied_count == COUNT_W'(TOTAL_SLOTS))
        else $error("full reported with free slots");
`endif
endmodule
